// ===== src/rwc_pkg.sv =====
`timescale 1ns / 1ps
package rwc_pkg;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CHDR   = 5'b00010,
        PH_FMT    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_DIV = 3'b010,
        S_OUT = 3'b100
    } t_state;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_CONT  = 2'd1;
    localparam logic [1:0] STS_BAD_AUDIO = 2'd2;
    localparam logic [1:0] STS_TRUNC     = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int unsigned LEN_W    = 33;
    localparam int unsigned DIV_STEPS = 32;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic verdict;
        logic need_mod;
        logic div_last;
    } t_sts;

endpackage

// ===== src/rwc_ifs.sv =====
`timescale 1ns / 1ps
interface rwc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       last_byte;
    modport source (output valid, output file_byte, output last_byte, input ready);
    modport sink (input valid, input file_byte, input last_byte, output ready);
endinterface

interface rwc_verdict_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] block_align;
    logic [31:0] data_bytes;
    modport source (output valid, output status, output block_align, output data_bytes,
                    input ready);
    modport sink (input valid, input status, input block_align, input data_bytes,
                  output ready);
endinterface

// ===== src/rwc_ctrl.sv =====
`timescale 1ns / 1ps
module rwc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  rwc_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output rwc_pkg::t_cmd o_cmd
);
    import rwc_pkg::*;

    t_state r_state, n_state;

    assign o_in_ready   = (r_state == S_RUN);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_cmd.take     = i_in_valid && o_in_ready;
    assign o_cmd.div_step = (r_state == S_DIV);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (o_cmd.take && i_sts.verdict) begin
                    n_state = i_sts.need_mod ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input open while word pending");
    a_back_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready) else $error("no return to run");
    a_div_last_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_last |-> (r_state == S_DIV)) else $error("divider end outside div");
endmodule

// ===== src/rwc_dp.sv =====
`timescale 1ns / 1ps
module rwc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [32:0]   i_cfg_data,
    input  logic [7:0]    i_file_byte,
    input  logic          i_last_byte,
    input  rwc_pkg::t_cmd i_cmd,
    output rwc_pkg::t_sts o_sts,
    output logic [1:0]    o_status,
    output logic [15:0]   o_block_align,
    output logic [31:0]   o_data_bytes
);
    import rwc_pkg::*;

    logic [LEN_W-1:0] r_flen;
    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_rend, n_rend;
    logic [63:0]      r_hs, n_hs;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [15:0]      r_align, n_align;
    logic             r_aseen, n_aseen;
    logic [31:0]      r_dsize, n_dsize;
    logic             r_dseen, n_dseen;
    logic             r_vgiven, n_vgiven;

    logic [1:0]  r_out_status;
    logic [15:0] r_out_align;
    logic [31:0] r_out_data;
    logic [31:0] r_div_q;
    logic [16:0] r_div_rem;
    logic [4:0]  r_div_cnt;

    logic        v, nc, mod;
    logic [1:0]  vcode;
    logic [15:0] cap_align;
    logic [31:0] cap_dsize;
    logic [31:0] size;
    logic [33:0] padded;
    logic [16:0] d_try, d_next;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_rend = r_rend; n_hs = r_hs;
        n_rem = r_rem; n_align = r_align; n_aseen = r_aseen;
        n_dsize = r_dsize; n_dseen = r_dseen; n_vgiven = r_vgiven;
        v = 1'b0; nc = 1'b0; mod = 1'b0; vcode = STS_OK;
        size = 32'd0; padded = 34'd0;
        if (!r_vgiven && r_flen != '0) begin
            if (r_phase == PH_HEADER && r_pos == '0 && r_flen < LEN_W'(12)) begin
                v = 1'b1; vcode = STS_BAD_CONT;
            end else begin
                n_pos = r_pos + LEN_W'(1);
                if (r_phase == PH_HEADER || r_phase == PH_CHDR) begin
                    n_hs = {i_file_byte, r_hs[63:8]};
                end
                case (r_phase)
                    PH_HEADER: begin
                        if (n_pos == LEN_W'(4)) begin
                            n_rem = LEN_W'(n_hs[63:32] != TAG_RIFF);
                        end
                        if (n_pos == LEN_W'(12)) begin
                            n_rend = {1'b0, n_hs[31:0]} + LEN_W'(8);
                            if (n_rem != '0 || n_hs[63:32] != TAG_WAVE
                                || n_rend < LEN_W'(12) || n_rend > r_flen) begin
                                v = 1'b1; vcode = STS_BAD_CONT;
                            end else begin
                                n_rem = '0; nc = 1'b1;
                            end
                        end
                    end
                    PH_CHDR: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (n_rem == '0) begin
                            size   = n_hs[63:32];
                            padded = {1'b0, n_pos} + {2'b0, size} + {33'b0, size[0]};
                            if (padded > {1'b0, r_rend}) begin
                                v = 1'b1; vcode = STS_BAD_CONT;
                            end else if (n_hs[31:0] == TAG_FMT && !r_aseen) begin
                                if (size < 32'd16) begin
                                    v = 1'b1; vcode = STS_BAD_CONT;
                                end else begin
                                    n_hs = 64'({1'b0, size} - 33'd16 + {32'b0, size[0]});
                                    n_rem = LEN_W'(16);
                                    n_phase = PH_FMT;
                                end
                            end else begin
                                if (n_hs[31:0] == TAG_DATA && !r_dseen) begin
                                    n_dsize = size; n_dseen = 1'b1;
                                end
                                n_rem = {1'b0, size} + {32'b0, size[0]};
                                if (n_rem == '0) begin
                                    nc = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_FMT: begin
                        // body bytes 12 and 13 hold the block alignment
                        if (r_rem == LEN_W'(4)) begin
                            n_align = {r_align[15:8], i_file_byte};
                        end else if (r_rem == LEN_W'(3)) begin
                            n_align = {i_file_byte, r_align[7:0]};
                        end
                        n_rem = r_rem - LEN_W'(1);
                        if (n_rem == '0) begin
                            n_aseen = 1'b1;
                            if (n_align == '0) begin
                                v = 1'b1; vcode = STS_BAD_AUDIO;
                            end else begin
                                n_rem = r_hs[LEN_W-1:0];
                                if (n_rem == '0) begin
                                    nc = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (n_rem == '0) begin
                            nc = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (nc) begin
                    if ({1'b0, n_pos} + 34'd8 <= {1'b0, n_rend}) begin
                        n_phase = PH_CHDR;
                        n_rem   = LEN_W'(8);
                    end else if (n_pos != n_rend || !n_aseen || !n_dseen) begin
                        v = 1'b1; vcode = STS_BAD_CONT;
                    end else if (n_align == '0) begin
                        v = 1'b1; vcode = STS_BAD_AUDIO;
                    end else begin
                        v = 1'b1; mod = 1'b1;
                    end
                end
            end
            if (!v && i_last_byte) begin
                v = 1'b1;
                vcode = (n_phase == PH_HEADER || n_phase == PH_FMT) ? STS_BAD_CONT
                                                                    : STS_TRUNC;
            end
        end
        cap_align = n_align;
        cap_dsize = n_dsize;
        if (v) begin
            n_vgiven = 1'b1;
            n_phase  = PH_DONE;
        end
        if (i_last_byte) begin
            n_phase = PH_HEADER; n_pos = '0; n_rend = '0; n_hs = '0; n_rem = '0;
            n_align = '0; n_aseen = 1'b0; n_dsize = '0; n_dseen = 1'b0;
            n_vgiven = 1'b0;
        end
    end

    // restoring remainder step, one quotient bit a cycle
    assign d_try  = {r_div_rem[15:0], r_div_q[31]};
    assign d_next = (d_try >= {1'b0, r_out_align}) ? d_try - {1'b0, r_out_align} : d_try;

    assign o_sts.verdict  = v;
    assign o_sts.need_mod = mod;
    assign o_sts.div_last = (r_div_cnt == 5'(DIV_STEPS - 1));

    assign o_status      = r_out_status;
    assign o_block_align = r_out_align;
    assign o_data_bytes  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen <= '0; r_phase <= PH_HEADER; r_pos <= '0; r_rend <= '0;
            r_hs <= '0; r_rem <= '0; r_align <= '0; r_aseen <= 1'b0;
            r_dsize <= '0; r_dseen <= 1'b0; r_vgiven <= 1'b0; r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_flen <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_rend <= n_rend; r_hs <= n_hs;
                r_rem <= n_rem; r_align <= n_align; r_aseen <= n_aseen;
                r_dsize <= n_dsize; r_dseen <= n_dseen; r_vgiven <= n_vgiven;
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && v) begin
            r_out_status <= vcode;
            r_out_align  <= cap_align;
            r_out_data   <= cap_dsize;
            r_div_q      <= cap_dsize;
            r_div_rem    <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[30:0], 1'b0};
            r_div_rem <= d_next;
            if (o_sts.div_last) begin
                r_out_status <= (d_next != '0) ? STS_BAD_AUDIO : STS_OK;
            end
        end
    end
endmodule

// ===== src/riff_wave_container_checker.sv =====
`timescale 1ns / 1ps
// a verdict word is registered when the deciding byte is taken and appears the cycle after,
// or once the remainder unit is done when the data size must be checked against the alignment
// throughput: one byte per cycle while parsing; input stalls while a verdict waits
// or the 32-step remainder unit runs
// reset: synchronous active-low, clears parse state and sets file_length to zero
module riff_wave_container_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [32:0]   i_cfg_data,
    rwc_byte_if.sink      i_byte_ch,
    rwc_verdict_if.source o_verdict_ch
);
    import rwc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller owns the handshakes and the divider sequencing
    rwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte_ch.valid),
        .i_out_ready (o_verdict_ch.ready),
        .i_sts       (sts),
        .o_in_ready  (i_byte_ch.ready),
        .o_out_valid (o_verdict_ch.valid),
        .o_cmd       (cmd)
    );

    // datapath walks the chunk headers and holds the verdict word
    rwc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_file_byte   (i_byte_ch.file_byte),
        .i_last_byte   (i_byte_ch.last_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_verdict_ch.status),
        .o_block_align (o_verdict_ch.block_align),
        .o_data_bytes  (o_verdict_ch.data_bytes)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import rwc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam logic [32:0] MASK33         = 33'h1_FFFF_FFFF;

    localparam logic [2:0] P_HEADER = 3'd0;
    localparam logic [2:0] P_CHDR   = 3'd1;
    localparam logic [2:0] P_FMT    = 3'd2;
    localparam logic [2:0] P_SKIP   = 3'd3;
    localparam logic [2:0] P_DONE   = 3'd4;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_align;
        logic [31:0] data_bytes;
    } t_verdict;

    // expected verdict words, checked in order
    class verdict_board;
        t_verdict pending[$];
        int       errors;

        function void note_verdict(t_verdict v);
            pending.push_back(v);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                $display("%0t unexpected verdict status=%0d align=%0d data=%0d",
                         $time, got.status, got.block_align, got.data_bytes);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.block_align !== want.block_align) begin
                $display("%0t block_align expected %0d actual %0d", $time,
                         want.block_align, got.block_align);
                errors++;
            end
            if (got.data_bytes !== want.data_bytes) begin
                $display("%0t data_bytes expected %0d actual %0d", $time,
                         want.data_bytes, got.data_bytes);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [32:0] i_cfg_data = '0;

    rwc_byte_if    byte_ch ();
    rwc_verdict_if verdict_ch ();

    riff_wave_container_checker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_byte_ch    (byte_ch.sink),
        .o_verdict_ch (verdict_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    verdict_board board = new();

    // predictor state, mirrors the parser
    logic [32:0] pr_file_len;
    logic [2:0]  pr_phase;
    logic [32:0] pr_pos;
    logic [32:0] pr_riff_end;
    logic [63:0] pr_shift;
    logic [32:0] pr_remain;
    logic [15:0] pr_align;
    logic        pr_align_seen;
    logic [31:0] pr_data_size;
    logic        pr_data_seen;
    logic        pr_done;

    int unsigned idle_cycles;
    logic        sink_hold;

    function automatic void parse_clear();
        pr_phase = P_HEADER;
        pr_pos = '0;
        pr_riff_end = '0;
        pr_shift = '0;
        pr_remain = '0;
        pr_align = '0;
        pr_align_seen = 1'b0;
        pr_data_size = '0;
        pr_data_seen = 1'b0;
        pr_done = 1'b0;
    endfunction

    // end of header or chunk: next header or final verdict
    function automatic int chunk_boundary();
        if ({1'b0, pr_pos} + 34'd8 <= {1'b0, pr_riff_end}) begin
            pr_phase = P_CHDR;
            pr_remain = 33'd8;
            return -1;
        end
        if (pr_pos != pr_riff_end || !pr_align_seen || !pr_data_seen)
            return int'(STS_BAD_CONT);
        if (pr_align == 16'd0 || (pr_data_size % pr_align) != 0)
            return int'(STS_BAD_AUDIO);
        return int'(STS_OK);
    endfunction

    function automatic int consume_byte(logic [7:0] b);
        logic [34:0] padded;
        logic [31:0] id;
        logic [31:0] size;
        pr_pos = (pr_pos + 33'd1) & MASK33;
        if (pr_phase == P_HEADER || pr_phase == P_CHDR)
            pr_shift = {b, pr_shift[63:8]};
        case (pr_phase)
            P_HEADER: begin
                if (pr_pos == 33'd4)
                    pr_remain = (pr_shift[63:32] != TAG_RIFF) ? 33'd1 : 33'd0;
                if (pr_pos == 33'd12) begin
                    pr_riff_end = {1'b0, pr_shift[31:0]} + 33'd8;
                    if (pr_remain != 0 || pr_shift[63:32] != TAG_WAVE ||
                        pr_riff_end < 33'd12 || pr_riff_end > pr_file_len)
                        return int'(STS_BAD_CONT);
                    pr_remain = '0;
                    return chunk_boundary();
                end
                return -1;
            end
            P_CHDR: begin
                pr_remain = pr_remain - 33'd1;
                if (pr_remain != 0) return -1;
                id = pr_shift[31:0];
                size = pr_shift[63:32];
                padded = {2'b0, pr_pos} + {3'b0, size} + {34'b0, size[0]};
                if (padded > {2'b0, pr_riff_end}) return int'(STS_BAD_CONT);
                if (id == TAG_FMT && !pr_align_seen) begin
                    if (size < 32'd16) return int'(STS_BAD_CONT);
                    pr_shift = {32'b0, size} - 64'd16 + {63'b0, size[0]};
                    pr_remain = 33'd16;
                    pr_phase = P_FMT;
                    return -1;
                end
                if (id == TAG_DATA && !pr_data_seen) begin
                    pr_data_size = size;
                    pr_data_seen = 1'b1;
                end
                pr_remain = {1'b0, size} + {32'b0, size[0]};
                if (pr_remain == 0) return chunk_boundary();
                pr_phase = P_SKIP;
                return -1;
            end
            P_FMT: begin
                if (pr_remain == 33'd4) pr_align[7:0] = b;
                else if (pr_remain == 33'd3) pr_align[15:8] = b;
                pr_remain = pr_remain - 33'd1;
                if (pr_remain != 0) return -1;
                pr_align_seen = 1'b1;
                if (pr_align == 16'd0) return int'(STS_BAD_AUDIO);
                pr_remain = pr_shift[32:0];
                if (pr_remain == 0) return chunk_boundary();
                pr_phase = P_SKIP;
                return -1;
            end
            P_SKIP: begin
                pr_remain = pr_remain - 33'd1;
                if (pr_remain == 0) return chunk_boundary();
                return -1;
            end
            default: return -1;
        endcase
    endfunction

    // one accepted byte word: predict and queue any verdict
    function automatic void predict_byte(logic [7:0] b, logic last);
        int v;
        t_verdict w;
        v = -1;
        if (!pr_done && pr_file_len != 0) begin
            if (pr_phase == P_HEADER && pr_pos == 0 && pr_file_len < 33'd12)
                v = int'(STS_BAD_CONT);
            else
                v = consume_byte(b);
            if (v < 0 && last)
                v = (pr_phase == P_HEADER || pr_phase == P_FMT) ?
                    int'(STS_BAD_CONT) : int'(STS_TRUNC);
        end
        if (v >= 0) begin
            w.status = v[1:0];
            w.block_align = pr_align;
            w.data_bytes = pr_data_size;
            board.note_verdict(w);
            pr_done = 1'b1;
            pr_phase = P_DONE;
        end
        if (last) parse_clear();
    endfunction

    // mostly short gaps, occasionally long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // idle time for the source; honors quiet phases
    logic quiet_src;

    // valid stays high across back-to-back words, drops only for a gap
    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        gap = quiet_src ? 0 : pick_gap();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.file_byte <= b;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        predict_byte(b, last);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(logic [32:0] len);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pr_file_len = len;
    endtask

    // file image built here, then streamed
    logic [7:0] img[$];

    task automatic put_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++) img.push_back(v[8*i +: 8]);
    endtask

    task automatic put_chunk(logic [31:0] id, logic [31:0] size, int unsigned body);
        put_le32(id);
        put_le32(size);
        for (int unsigned i = 0; i < body; i++) img.push_back(8'($urandom));
    endtask

    task automatic put_fmt(logic [15:0] align, int unsigned size);
        put_le32(TAG_FMT);
        put_le32(size);
        for (int unsigned i = 0; i < size + (size & 1); i++) begin
            if (i == 12) img.push_back(align[7:0]);
            else if (i == 13) img.push_back(align[15:8]);
            else img.push_back(8'($urandom));
        end
    endtask

    // well-formed file, optionally damaged, of random shape
    task automatic build_file(logic [15:0] align);
        int unsigned body;
        int unsigned dsize;
        int unsigned n;
        img.delete();
        put_le32(TAG_RIFF);
        put_le32(32'd0);
        put_le32(TAG_WAVE);
        if ($urandom_range(3) == 0) put_chunk(32'h5453_494C, 3, 4);
        put_fmt(align, $urandom_range(3) == 0 ? $urandom_range(21, 16) : 16);
        if ($urandom_range(4) == 0) put_chunk(32'h6B6E_756A, 0, 0);
        n = $urandom_range(4, 1);
        dsize = ($urandom_range(3) == 0) ? $urandom_range(15) : n * int'(align);
        if (dsize > 60) dsize = $urandom_range(60);
        put_chunk(TAG_DATA, dsize, dsize + (dsize & 1));
        if ($urandom_range(4) == 0) put_chunk(TAG_DATA, 1, 2);
        body = img.size() - 8;
        img[4] = body[7:0];
        img[5] = body[15:8];
        img[6] = 8'd0;
        img[7] = 8'd0;
    endtask

    task automatic send_file(logic [32:0] len);
        if (pr_file_len != len) write_length(len);
        for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
    endtask

    int unsigned sent_items;
    int unsigned kind;
    logic [31:0] rsize;

    // sink: random stalls, with quiet stretches
    initial begin
        verdict_ch.ready = 1'b0;
        sink_hold = 1'b0;
        forever begin
            @(posedge i_clk);
            if (verdict_ch.valid && verdict_ch.ready)
                board.check_verdict({verdict_ch.status, verdict_ch.block_align,
                                     verdict_ch.data_bytes});
            if (sink_hold || $urandom_range(5) != 0)
                verdict_ch.ready <= 1'b1;
            else
                verdict_ch.ready <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready) ||
            !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.file_byte = '0;
        byte_ch.last_byte = 1'b0;
        idle_cycles = 0;
        quiet_src = 1'b0;
        pr_file_len = '0;
        parse_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length: bytes ignored, last still restarts
        send_byte(8'h52, 1'b0);
        send_byte(8'hFF, 1'b1);
        // short file rejected on first byte
        write_length(33'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_length(33'd11);
        send_byte(8'h52, 1'b1);
        // header cut short
        write_length(33'd100);
        send_byte(8'h52, 1'b0);
        send_byte(8'h49, 1'b1);
        // bad tag
        img.delete();
        put_le32(32'h5846_4952); put_le32(32'd4); put_le32(TAG_WAVE);
        send_file(33'd100);
        // largest riff size, still within the maximum file length
        img.delete();
        put_le32(TAG_RIFF); put_le32(32'hFFFF_FFFF); put_le32(TAG_WAVE);
        send_file(MASK33);
        // valid file at maximum length register, zero align, short fmt
        build_file(16'd4);
        send_file(MASK33);
        build_file(16'd0);
        send_file(33'(img.size()));
        img.delete();
        put_le32(TAG_RIFF); put_le32(32'd20); put_le32(TAG_WAVE); put_chunk(TAG_FMT, 8, 8);
        send_file(33'd28);
        // everything accepted so far settles before the random part
        quiet_src = 1'b1;
        sink_hold = 1'b1;
        wait_drained();
        sink_hold = 1'b0;
        quiet_src = 1'b0;

        sent_items = 0;
        while (sent_items < 1200) begin
            kind = $urandom_range(99);
            build_file(16'($urandom_range(6)));
            if (kind < 70) begin
                send_file(33'(img.size()) + 33'($urandom_range(2)));
            end else if (kind < 80) begin
                // truncated stream
                img = img[0:$urandom_range(img.size() - 1)];
                send_file(33'd200);
            end else if (kind < 90) begin
                // corrupt one byte
                img[$urandom_range(img.size() - 1)] = 8'($urandom);
                send_file(33'(img.size()));
            end else if (kind < 95) begin
                // extra random bytes after the file data
                rsize = $urandom_range(8);
                for (int i = 0; i < rsize; i++) img.push_back(8'($urandom));
                send_file(33'(img.size()) - 33'($urandom_range(1)));
            end else begin
                img.delete();
                rsize = $urandom_range(30, 1);
                for (int i = 0; i < rsize; i++) img.push_back(8'($urandom));
                send_file(33'($urandom_range(40)));
            end
            sent_items += img.size();
        end

        wait_drained();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rwc_pkg.sv
src/rwc_ifs.sv
src/rwc_ctrl.sv
src/rwc_dp.sv
src/riff_wave_container_checker.sv
tb/testbench.sv
